@@ hw/rtl/s2rgba_pkg.sv @@
package s2rgba_pkg;

    localparam int LANES = 4;
    localparam int DIV_STEPS = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_VALUE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_VALUE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_COLOR  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_COLOR = 3'd4;

    localparam logic                     MODE_LINEAR     = 1'b0;
    localparam logic [CFG_DATA_BITS-1:0] LOW_VALUE_RST   = 32'h0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] HIGH_VALUE_RST  = 32'h0001_0000;
    localparam logic [CFG_DATA_BITS-1:0] LOW_COLOR_RST   = 32'h0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] HIGH_COLOR_RST  = 32'hFFFF_FFFF;

    localparam logic [7:0] BYTE_MAX = 8'hFF;

    typedef logic [LANES-1:0][7:0] byte_lanes_t;

endpackage

@@ hw/rtl/s2rgba_in_if.sv @@
interface s2rgba_in_if #(
    parameter int SAMPLE_BITS = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in;

    modport source (output valid, sample, last_in, input ready);
    modport sink (input valid, sample, last_in, output ready);
endinterface

@@ hw/rtl/s2rgba_out_if.sv @@
interface s2rgba_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_out;

    modport source (output valid, red, green, blue, alpha, last_out, input ready);
    modport sink (input valid, red, green, blue, alpha, last_out, output ready);
endinterface

@@ hw/rtl/s2rgba_cfg_if.sv @@
interface s2rgba_cfg_if
    import s2rgba_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/scalar_to_rgba_colormap_core.sv @@
// Scalar to RGBA colormap.
//
// samples: one signed fixed-point word per cycle (sample, last_in).
// pixels:  one RGBA word per accepted sample (red, green, blue, alpha, last_out),
//          in order, last_out copied from last_in.
// cfg:     register writes (index, data), always ready; write only while the
//          pipeline is empty.
//
// Throughput: one word per cycle while pixels.ready is high. The pipeline has
// 13 stages: capture, bound compare, operand select, channel product, eight
// restoring quotient steps (one bit each, four channel lanes side by side) and
// the output register. The quotient steps set the depth.
//
// Reset empties the pipeline and loads the default map (linear, 0.0 to 1.0,
// black to white). When pixels.ready is low the output word holds and each
// stage stalls only once the stage after it is full, so bubbles close up
// and samples keeps taking words until the whole pipeline is full.
module scalar_to_rgba_colormap_core
    import s2rgba_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    s2rgba_in_if.sink     samples,
    s2rgba_out_if.source  pixels,
    s2rgba_cfg_if.sink    cfg
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SAMPLE_BITS + DIV_STEPS;
    localparam int NS = DIV_STEPS + 5;
    localparam int DS = 3;

    function automatic logic [SB-1:0] mag(input logic [SB-1:0] x);
        mag = x[SB-1] ? (~x + 1'b1) : x;
    endfunction

    // configuration
    logic                     mode_reg;
    logic [CFG_DATA_BITS-1:0] low_value_reg;
    logic [CFG_DATA_BITS-1:0] high_value_reg;
    logic [CFG_DATA_BITS-1:0] low_color_reg;
    logic [CFG_DATA_BITS-1:0] high_color_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LINEAR;
            low_value_reg  <= LOW_VALUE_RST;
            high_value_reg <= HIGH_VALUE_RST;
            low_color_reg  <= LOW_COLOR_RST;
            high_color_reg <= HIGH_COLOR_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAP_MODE:   mode_reg       <= cfg.data[0];
                REG_LOW_VALUE:  low_value_reg  <= cfg.data;
                REG_HIGH_VALUE: high_value_reg <= cfg.data;
                REG_LOW_COLOR:  low_color_reg  <= cfg.data;
                REG_HIGH_COLOR: high_color_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    logic [SB-1:0] lv;
    logic [SB-1:0] hv;

    generate
        if (SB <= CFG_DATA_BITS)
        begin : g_narrow
            assign lv = low_value_reg[SB-1:0];
            assign hv = high_value_reg[SB-1:0];
        end
        else
        begin : g_wide
            assign lv = {{(SB-CFG_DATA_BITS){1'b0}}, low_value_reg};
            assign hv = {{(SB-CFG_DATA_BITS){1'b0}}, high_value_reg};
        end
    endgenerate

    // flow control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || pixels.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign samples.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= samples.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: capture
    logic [SB-1:0] s0_sample_reg;
    logic          s0_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_sample_reg <= samples.sample;
            s0_last_reg   <= samples.last_in;
        end
    end

    // stage 1: bound compares on offset-binary values
    logic [SB-1:0] bs;
    logic [SB-1:0] bl;
    logic [SB-1:0] bh;
    logic          asc;
    logic          desc;
    logic [SB-1:0] lden_next;
    logic [SB-1:0] lnum_next;
    logic [SB-1:0] ml;
    logic [SB-1:0] mh;

    assign bs   = {~s0_sample_reg[SB-1], s0_sample_reg[SB-2:0]};
    assign bl   = {~lv[SB-1], lv[SB-2:0]};
    assign bh   = {~hv[SB-1], hv[SB-2:0]};
    assign asc  = bh > bl;
    assign desc = bh < bl;
    assign ml   = mag(lv);
    assign mh   = mag(hv);

    always_comb
    begin
        if (asc)
        begin
            lden_next = bh - bl;
        end
        else if (desc)
        begin
            lden_next = bl - bh;
        end
        else
        begin
            lden_next = SB'(1);
        end

        lnum_next = '0;
        if (asc)
        begin
            if (bs <= bl)
            begin
                lnum_next = '0;
            end
            else if (bs >= bh)
            begin
                lnum_next = bh - bl;
            end
            else
            begin
                lnum_next = bs - bl;
            end
        end
        else if (desc)
        begin
            if (bs >= bl)
            begin
                lnum_next = '0;
            end
            else if (bs <= bh)
            begin
                lnum_next = bl - bh;
            end
            else
            begin
                lnum_next = bl - bs;
            end
        end
    end

    logic          s1_mode_reg;
    logic          s1_neg_reg;
    logic [SB-1:0] s1_a_reg;
    logic [SB-1:0] s1_m_reg;
    logic [SB-1:0] s1_lnum_reg;
    logic [SB-1:0] s1_lden_reg;
    logic          s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_mode_reg <= mode_reg;
            s1_neg_reg  <= s0_sample_reg[SB-1];
            s1_a_reg    <= mag(s0_sample_reg);
            s1_m_reg    <= (mh > ml) ? mh : ml;
            s1_lnum_reg <= lnum_next;
            s1_lden_reg <= lden_next;
            s1_last_reg <= s0_last_reg;
        end
    end

    // stage 2: ratio operands and per-channel step
    logic [SB-1:0]        num_next;
    logic [SB-1:0]        den_next;
    byte_lanes_t          d_next;
    byte_lanes_t          base_next;
    logic [LANES-1:0]     dn_next;

    always_comb
    begin
        if (s1_mode_reg == MODE_LINEAR)
        begin
            num_next = s1_lnum_reg;
            den_next = s1_lden_reg;
        end
        else if (s1_m_reg == '0)
        begin
            num_next = '0;
            den_next = SB'(1);
        end
        else if (s1_a_reg >= s1_m_reg)
        begin
            num_next = s1_m_reg;
            den_next = s1_m_reg;
        end
        else
        begin
            num_next = s1_a_reg;
            den_next = s1_m_reg;
        end

        for (int l = 0; l < LANES; l++)
        begin
            if (s1_mode_reg == MODE_LINEAR)
            begin
                dn_next[l]   = high_color_reg[8*l +: 8] < low_color_reg[8*l +: 8];
                d_next[l]    = dn_next[l]
                             ? low_color_reg[8*l +: 8] - high_color_reg[8*l +: 8]
                             : high_color_reg[8*l +: 8] - low_color_reg[8*l +: 8];
                base_next[l] = low_color_reg[8*l +: 8];
            end
            else
            begin
                dn_next[l]   = 1'b1;
                d_next[l]    = s1_neg_reg ? low_color_reg[8*l +: 8]
                                          : high_color_reg[8*l +: 8];
                base_next[l] = BYTE_MAX;
            end
        end
        // diverging alpha stays opaque
        if (s1_mode_reg != MODE_LINEAR)
        begin
            d_next[LANES-1] = '0;
        end
    end

    logic [SB-1:0]    s2_num_reg;
    logic [SB-1:0]    s2_den_reg;
    byte_lanes_t      s2_d_reg;
    byte_lanes_t      s2_base_reg;
    logic [LANES-1:0] s2_dn_reg;
    logic             s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_num_reg  <= num_next;
            s2_den_reg  <= den_next;
            s2_d_reg    <= d_next;
            s2_base_reg <= base_next;
            s2_dn_reg   <= dn_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stages 3..11: channel product, then one quotient bit per stage
    logic [PW-1:0]        rem_reg  [0:DIV_STEPS][0:LANES-1];
    logic [DIV_STEPS-1:0] q_reg    [0:DIV_STEPS][0:LANES-1];
    logic [SB-1:0]        den_reg  [0:DIV_STEPS];
    byte_lanes_t          base_reg [0:DIV_STEPS];
    logic [LANES-1:0]     dn_reg   [0:DIV_STEPS];
    logic                 last_reg [0:DIV_STEPS];

    logic [PW-1:0]        rem_next [1:DIV_STEPS][0:LANES-1];
    logic [DIV_STEPS-1:0] q_next   [1:DIV_STEPS][0:LANES-1];
    logic [PW-1:0]        trial    [1:DIV_STEPS];

    always_comb
    begin
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            trial[k] = PW'(den_reg[k-1]) << (DIV_STEPS - k);
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_reg[k-1][l] >= trial[k])
                begin
                    rem_next[k][l] = rem_reg[k-1][l] - trial[k];
                    q_next[k][l]   = {q_reg[k-1][l][DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = rem_reg[k-1][l];
                    q_next[k][l]   = {q_reg[k-1][l][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DS])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= PW'(s2_num_reg) * PW'(s2_d_reg[l]);
                q_reg[0][l]   <= '0;
            end
            den_reg[0]  <= s2_den_reg;
            base_reg[0] <= s2_base_reg;
            dn_reg[0]   <= s2_dn_reg;
            last_reg[0] <= s2_last_reg;
        end
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            if (en[DS+k])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                end
                den_reg[k]  <= den_reg[k-1];
                base_reg[k] <= base_reg[k-1];
                dn_reg[k]   <= dn_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // stage 12: round each channel toward the smaller value and apply
    byte_lanes_t pix_next;
    logic [8:0]  qext [0:LANES-1];
    logic [8:0]  sum  [0:LANES-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            qext[l] = {1'b0, q_reg[DIV_STEPS][l]}
                    + {8'b0, dn_reg[DIV_STEPS][l] && (rem_reg[DIV_STEPS][l] != '0)};
            sum[l]  = dn_reg[DIV_STEPS][l]
                    ? {1'b0, base_reg[DIV_STEPS][l]} - qext[l]
                    : {1'b0, base_reg[DIV_STEPS][l]} + qext[l];
            pix_next[l] = sum[l][7:0];
        end
    end

    byte_lanes_t pix_reg;
    logic        pix_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            pix_reg      <= pix_next;
            pix_last_reg <= last_reg[DIV_STEPS];
        end
    end

    assign pixels.valid    = v_reg[NS-1];
    assign pixels.red      = pix_reg[0];
    assign pixels.green    = pix_reg[1];
    assign pixels.blue     = pix_reg[2];
    assign pixels.alpha    = pix_reg[3];
    assign pixels.last_out = pix_last_reg;

    a_empty_out_takes_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        !pixels.valid |-> samples.ready
    ) else $error("input stalled with an empty output stage");

    a_operands_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> (s2_den_reg != '0) && (s2_num_reg <= s2_den_reg)
    ) else $error("ratio operands out of range");

    a_quotient_fits: assert property (
        @(posedge clk) disable iff (!rst_n)
        v_reg[DS] |-> (rem_reg[0][0] < (PW'(den_reg[0]) << DIV_STEPS))
                   && (rem_reg[0][1] < (PW'(den_reg[0]) << DIV_STEPS))
                   && (rem_reg[0][2] < (PW'(den_reg[0]) << DIV_STEPS))
    ) else $error("channel product exceeds quotient range");

    a_final_remainder: assert property (
        @(posedge clk) disable iff (!rst_n)
        v_reg[NS-2] |-> (rem_reg[DIV_STEPS][0] < PW'(den_reg[DIV_STEPS]))
                     && (rem_reg[DIV_STEPS][3] < PW'(den_reg[DIV_STEPS]))
    ) else $error("remainder not below divisor after last step");

    a_stalled_output_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pixels.valid && !pixels.ready) |=> pixels.valid && $stable(pix_reg)
    ) else $error("output word changed while stalled");

endmodule
